// ===== rtl/lkvt_pkg.sv =====
// Shared constants, codes and types of the locked key/value table.
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

   // Table geometry
   localparam int ENTRIES     = 16;
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BYTES = 8;

   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int VAL_W = 8 * VALUE_BYTES;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Port field widths
   localparam int MODE_W   = 3;
   localparam int REQID_W  = 22;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request modes
   localparam mode_type MODE_PUT   = 3'd0;
   localparam mode_type MODE_GET   = 3'd1;
   localparam mode_type MODE_DEL   = 3'd2;
   localparam mode_type MODE_BEGIN = 3'd3;
   localparam mode_type MODE_END   = 3'd4;

   // Response status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_LOCKED    = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_REFUSED   = 3'd4;
   localparam status_type ST_EMPTY     = 3'd5;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_GETV,
      S_SHRD,
      S_SHWR
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lkvt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lkvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/locked_key_value_table.sv =====
// Top level: request sequencer, shared key comparator and the two table RAMs.
// Response timing: lock, unused-mode, locked-out and empty-key words and any word on an empty table
//   respond in the cycle after acceptance; otherwise the held slots are walked in order, each
//   read (S_READ) then compared (S_CMP); a hit or a miss responds, a get hit after S_GETV.
// Delete shifts later pairs down, each read (S_SHRD) then written one slot lower (S_SHWR), then
//   responds; the table holds at most 15 pairs. Busy is high through the walk and a new word
//   is taken in the response cycle; no receiver stall.
// Reset (synchronous) clears the entry count and the lock owner; the tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module locked_key_value_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_start,
   output logic                                busy,
   input  wire logic [lkvt_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [lkvt_pkg::REQID_W-1:0]   req_requester,
   input  wire logic [lkvt_pkg::DATA_W-1:0]    req_key,
   input  wire logic [lkvt_pkg::DATA_W-1:0]    req_value,
   output logic                                rsp_valid,
   output logic [lkvt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lkvt_pkg::DATA_W-1:0]         rsp_read_value
);

   import lkvt_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [REQID_W-1:0]    lock_ff, lock_in;
   mode_type              mode_ff, mode_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VAL_W-1:0]      value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                  key_we, val_we;
   logic [IDX_W-1:0]      key_wa, val_wa, rd_addr;
   logic [KEY_W-1:0]      key_wd, key_rd;
   logic [VAL_W-1:0]      val_wd, val_rd;

   logic [KEY_W-1:0]      req_key_m;
   logic                  locked_out;
   logic                  key_hit;
   logic                  more_slots;
   logic                  more_shift;
   logic                  has_room;

   // Table storage
   lkvt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_wd),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lkvt_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   // Shared compare unit and slot bounds
   assign req_key_m  = req_key[KEY_W-1:0];
   assign locked_out = (lock_ff != '0) && (lock_ff != req_requester);
   assign key_hit    = (key_rd == key_ff);
   assign more_slots = (SUM_W'(idx_ff) + SUM_W'(1)) < SUM_W'(count_ff);
   assign more_shift = (SUM_W'(idx_ff) + SUM_W'(2)) < SUM_W'(count_ff);
   assign has_room   = (SUM_W'(count_ff) + SUM_W'(1)) < SUM_W'(ENTRIES);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         lock_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lock_ff      <= lock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Sequence one request
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      lock_in       = lock_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      key_we        = 1'b0;
      val_we        = 1'b0;
      key_wa        = idx_ff;
      val_wa        = idx_ff;
      key_wd        = key_rd;
      val_wd        = val_rd;
      rd_addr       = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               mode_in      = req_mode;
               key_in       = req_key_m;
               value_in     = req_value[VAL_W-1:0];
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               case (req_mode) inside
                  MODE_PUT, MODE_GET, MODE_DEL: begin
                     if (locked_out) begin
                        rsp_status_in = ST_LOCKED;
                     end else if (req_key_m == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (count_ff == '0) begin
                        // empty table: append or miss at once
                        if (req_mode == MODE_PUT) begin
                           key_we   = 1'b1;
                           val_we   = 1'b1;
                           key_wa   = count_ff[IDX_W-1:0];
                           val_wa   = count_ff[IDX_W-1:0];
                           key_wd   = req_key_m;
                           val_wd   = req_value[VAL_W-1:0];
                           count_in = count_ff + CNT_W'(1);
                        end else begin
                           rsp_status_in = ST_NOT_FOUND;
                        end
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  MODE_BEGIN: begin
                     if (lock_ff == '0 && req_requester != '0) begin
                        lock_in = req_requester;
                     end else begin
                        rsp_status_in = ST_REFUSED;
                     end
                  end
                  MODE_END: begin
                     if (lock_ff != '0 && lock_ff == req_requester) begin
                        lock_in = '0;
                     end else begin
                        rsp_status_in = ST_REFUSED;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_CMP;
         end

         S_CMP: begin
            if (key_hit) begin
               if (mode_ff == MODE_PUT) begin
                  val_we       = 1'b1;
                  val_wd       = value_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (mode_ff == MODE_GET) begin
                  // value word of this slot arrives next cycle
                  state_in = S_GETV;
               end else if (more_slots) begin
                  state_in = S_SHRD;
               end else begin
                  count_in     = count_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (more_slots) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (mode_ff == MODE_PUT) begin
                  if (has_room) begin
                     key_we   = 1'b1;
                     val_we   = 1'b1;
                     key_wa   = count_ff[IDX_W-1:0];
                     val_wa   = count_ff[IDX_W-1:0];
                     key_wd   = key_ff;
                     val_wd   = value_ff;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
         end

         S_GETV: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = DATA_W'(val_rd);
            state_in     = S_IDLE;
         end

         S_SHRD: begin
            // fetch the next pair
            rd_addr  = idx_ff + IDX_W'(1);
            state_in = S_SHWR;
         end

         S_SHWR: begin
            // move the fetched pair down one slot
            key_we = 1'b1;
            val_we = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (more_shift) begin
               state_in = S_SHRD;
            end else begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

`ifndef SYNTHESIS
   // The table never holds more than ENTRIES-1 pairs
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES - 1))
      else $error("entry count beyond table limit");

   // A compare only ever looks at a held slot
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (SUM_W'(idx_ff) < SUM_W'(count_ff)))
      else $error("compare on a slot past the entry count");

   // A nonzero read value only comes with an ok status
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_value_ff != '0) |-> (rsp_status_ff == ST_OK))
      else $error("read value on a failed response");

   // The lock owner changes only on an accepted request
   a_lock_change: assert property (@(posedge clock) disable iff (reset)
      (!$stable(lock_ff) && !$past(reset)) |-> $past(req_start && !busy))
      else $error("lock owner changed without a request");

   // A walk always ends in exactly one response
   a_walk_resp: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(reset) && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("walk finished without a response");
`endif

endmodule

`default_nettype wire
